### rtl/ftrg_pkg.sv
// ----------------------------------------------------------------------------
// ftrg_pkg: shared types and constants
// Item structs, op codes, controller states and the controller/datapath
// command and status groups of the top-two removal gain block.
// ----------------------------------------------------------------------------
package ftrg_pkg;

	localparam int FACILITIES = 1024;
	localparam int ADDR_W     = (FACILITIES > 1) ? $clog2(FACILITIES) : 1;

	localparam int OP_W     = 2;
	localparam int PROFIT_W = 16;
	localparam int FAC_W    = 10;
	localparam int SUM_W    = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ENTRY = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_QUERY   = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [PROFIT_W-1:0] profit;
		logic [FAC_W-1:0]    facility;
		logic                is_open;
		logic                last_of_client;
	} in_item_t;

	typedef struct packed {
		logic                kind;
		logic                best_found;
		logic [FAC_W-1:0]    best_facility;
		logic [PROFIT_W-1:0] best_profit;
		logic [PROFIT_W-1:0] second_profit;
		logic [SUM_W-1:0]    total_profit;
		logic [SUM_W-1:0]    removal_gain;
		logic                keep_open;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_QUERY
	} state_t;

	typedef struct packed {
		logic take;    // transfer accepted: update running top two, read gain store
		logic upd;     // close client: write gain, add total, load summary
		logic qry;     // load query answer
		logic clr_wr;  // write one zero entry of the clearing pass
	} cmd_t;

	typedef struct packed {
		logic out_free;  // output register can take a result this cycle
		logic clr_last;  // clearing pass is at its last entry
	} sts_t;

endpackage

### rtl/ftrg_ctrl.sv
// ----------------------------------------------------------------------------
// ftrg_ctrl: sequencing controller
// Accepts input transfers, steps through gain store read/update, query
// answer and the clearing pass, and commands the datapath.
// ----------------------------------------------------------------------------
module ftrg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [ftrg_pkg::OP_W-1:0] in_op,
	input  logic                  in_last,
	output logic                  in_stall,
	input  ftrg_pkg::sts_t        sts,
	output ftrg_pkg::cmd_t        cmd
);
	import ftrg_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_op == OP_ENTRY && in_last) state_nxt = ST_UPDATE;
					else if (in_op == OP_QUERY) state_nxt = ST_QUERY;
					else if (in_op == OP_CLEAR) state_nxt = ST_CLEAR;
				end
			end
			ST_UPDATE, ST_QUERY: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			ST_UPDATE: begin
				cmd.upd = sts.out_free;
			end
			ST_QUERY: begin
				cmd.qry = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_clear_op_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_op == OP_CLEAR) |=> state_q == ST_CLEAR)
		else $error("clear op did not start the clearing pass");

	a_update_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after client update");

	a_update_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && !sts.out_free) |=> state_q == ST_UPDATE)
		else $error("client update left while output register was full");

endmodule

### rtl/ftrg_datapath.sv
// ----------------------------------------------------------------------------
// ftrg_datapath: top-two tracking, gain store and result register
// Holds the running top two, the saturating total, the gain store memory,
// the fixed cost register and the output register.
// ----------------------------------------------------------------------------
module ftrg_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ftrg_pkg::cmd_t             cmd,
	output ftrg_pkg::sts_t             sts,
	input  ftrg_pkg::in_item_t         in_data,
	input  logic                       cfg_we,
	input  logic [ftrg_pkg::SUM_W-1:0] cfg_data,
	input  logic                       out_stall,
	output logic                       out_valid,
	output ftrg_pkg::out_item_t        out_data
);
	import ftrg_pkg::*;

	logic [SUM_W-1:0]    mem [FACILITIES];

	logic [SUM_W-1:0]    open_cost_q;
	logic [PROFIT_W-1:0] run_best_q;
	logic [PROFIT_W-1:0] run_second_q;
	logic [FAC_W-1:0]    run_idx_q;
	logic                run_valid_q;
	logic [SUM_W-1:0]    profit_sum_q;
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic [SUM_W-1:0]    rd_data_q;
	logic                hit_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [PROFIT_W-1:0] nxt_best;
	logic [PROFIT_W-1:0] nxt_second;
	logic [FAC_W-1:0]    nxt_idx;
	logic                nxt_valid;
	logic [FAC_W-1:0]    rd_fac;
	logic                rd_hit;
	logic [ADDR_W-1:0]   rd_addr;
	logic [SUM_W:0]      gain_sum;
	logic [SUM_W-1:0]    gain_new;
	logic [SUM_W:0]      total_sum;
	logic [SUM_W-1:0]    total_new;
	logic [SUM_W-1:0]    qry_gain;
	logic                gain_wr;

	// fold the incoming entry into the running top two, later ties win
	always_comb begin
		nxt_best   = run_best_q;
		nxt_second = run_second_q;
		nxt_idx    = run_idx_q;
		nxt_valid  = run_valid_q;
		if (in_data.is_open) begin
			if (in_data.profit >= run_best_q) begin
				nxt_second = run_best_q;
				nxt_best   = in_data.profit;
				nxt_idx    = in_data.facility;
				nxt_valid  = 1'b1;
			end else if (in_data.profit >= run_second_q) begin
				nxt_second = in_data.profit;
			end
		end
	end

	assign rd_fac  = (in_data.op == OP_ENTRY) ? nxt_idx : in_data.facility;
	assign rd_hit  = int'(rd_fac) < FACILITIES;
	assign rd_addr = ADDR_W'(rd_fac);

	assign gain_sum  = {1'b0, rd_data_q}
		+ {{(SUM_W + 1 - PROFIT_W){1'b0}}, run_best_q - run_second_q};
	assign gain_new  = gain_sum[SUM_W] ? '1 : gain_sum[SUM_W-1:0];
	assign total_sum = {1'b0, profit_sum_q} + {{(SUM_W + 1 - PROFIT_W){1'b0}}, run_best_q};
	assign total_new = total_sum[SUM_W] ? '1 : total_sum[SUM_W-1:0];
	assign qry_gain  = hit_q ? rd_data_q : '0;
	assign gain_wr   = cmd.upd && run_valid_q && hit_q;

	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.clr_last = clr_cnt_q == ADDR_W'(FACILITIES - 1);

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[clr_cnt_q] <= '0;
		end else if (gain_wr) begin
			mem[ADDR_W'(run_idx_q)] <= gain_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			hit_q <= rd_hit;
			if (rd_hit) rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_cost_q  <= '0;
			run_best_q   <= '0;
			run_second_q <= '0;
			run_idx_q    <= '0;
			run_valid_q  <= 1'b0;
			profit_sum_q <= '0;
			clr_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) open_cost_q <= cfg_data;

			if (cmd.take && in_data.op == OP_ENTRY) begin
				run_best_q   <= nxt_best;
				run_second_q <= nxt_second;
				run_idx_q    <= nxt_idx;
				run_valid_q  <= nxt_valid;
			end else if (cmd.upd) begin
				run_best_q   <= '0;
				run_second_q <= '0;
				run_idx_q    <= '0;
				run_valid_q  <= 1'b0;
			end

			if (cmd.clr_wr) begin
				profit_sum_q <= '0;
				clr_cnt_q    <= sts.clr_last ? '0 : clr_cnt_q + 1'b1;
			end else if (cmd.upd && run_valid_q) begin
				profit_sum_q <= total_new;
			end

			if (cmd.upd || cmd.qry) out_valid_q <= 1'b1;
			else if (!out_stall)    out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			out_q.kind          <= KIND_SUMMARY;
			out_q.best_found    <= run_valid_q;
			out_q.best_facility <= run_idx_q;
			out_q.best_profit   <= run_best_q;
			out_q.second_profit <= run_second_q;
			out_q.total_profit  <= run_valid_q ? total_new : profit_sum_q;
			out_q.removal_gain  <= '0;
			out_q.keep_open     <= 1'b0;
		end else if (cmd.qry) begin
			out_q.kind          <= KIND_QUERY;
			out_q.best_found    <= 1'b0;
			out_q.best_facility <= '0;
			out_q.best_profit   <= '0;
			out_q.second_profit <= '0;
			out_q.total_profit  <= profit_sum_q;
			out_q.removal_gain  <= qry_gain;
			out_q.keep_open     <= qry_gain >= open_cost_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.upd, cmd.qry, cmd.clr_wr}))
		else $error("datapath commands overlap");

	a_top_two_order: assert property (@(posedge clk) disable iff (!arst_n)
		run_second_q <= run_best_q)
		else $error("second-best profit exceeds best profit");

	a_update_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> (!run_valid_q && out_valid_q && out_data.kind == KIND_SUMMARY))
		else $error("client close did not clear the run or load a summary");

	a_query_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.qry |=> (out_valid_q && out_data.kind == KIND_QUERY))
		else $error("query did not load an answer");

endmodule

### rtl/facility_top_two_removal_gain.sv
// ----------------------------------------------------------------------------
// facility_top_two_removal_gain: per-client top-two profit and removal gain
// Streams profit entries, reports each client's best and second-best open
// profit, accumulates removal gains per facility and answers gain queries.
// ----------------------------------------------------------------------------
// A profit entry without the last-of-client mark is taken in the idle state,
// so entries stream at one per cycle while the block is idle. An entry that
// ends a client and a facility query each first read the gain store, which
// has a single write port and a registered read, and then update it or form
// the answer; either waits for that second step while the output register
// still holds an untaken result. A clear op starts a clearing pass over all
// FACILITIES (1024) entries that writes the gain store one entry per cycle;
// the same pass runs after reset. No item is accepted during the pass, while
// opening cost writes are taken at any time. Results leave through an output
// register, so the next item can be taken while a result waits. Ties on
// profit go to the later entry; total and gains saturate.
// ----------------------------------------------------------------------------
module facility_top_two_removal_gain (
	input  logic                       clk,
	input  logic                       arst_n,
	// input item channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  ftrg_pkg::in_item_t         in_data,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output ftrg_pkg::out_item_t        out_data,
	// opening cost register write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ftrg_pkg::SUM_W-1:0] cfg_data
);
	import ftrg_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	// the register is a plain flop: take every write transfer at once
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// controller: handshake, sequencing, clearing pass
	ftrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.op),
		.in_last  (in_data.last_of_client),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: running top two, gain store, total, output register
	ftrg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
